FILE: src/lsb_pkg.sv
// Shared types and codes for the LSB payload extractor.
package lsb_pkg;

    // Width of the hidden length fields and the largest magic string.
    localparam int LengthBits = 32;
    localparam int MaxMagic   = 8;

    // Result kinds.
    localparam logic [1:0] KIND_EXT      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;
    localparam logic [1:0] KIND_EMPTY    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEADER_SKIP = 2'd0;
    localparam logic [1:0] REG_MAGIC_LEN   = 2'd1;
    localparam logic [1:0] REG_MAGIC_VALUE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [9:0]  HEADER_SKIP_RST = 10'd54;
    localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;
    localparam logic [63:0] MAGIC_VALUE_RST = 64'd8998;

    // One input beat.
    typedef struct packed {
        logic [7:0] image_byte;
        logic       first;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } t_out_item;

endpackage

FILE: src/lsb_stego_payload_extractor.sv
// Top level of the LSB steganography payload extractor.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  input   | in        | i_valid / o_stall      | i_in  (image_byte, first)
//  output  | out       | o_valid / i_stall      | o_out (out_byte, kind, last)
//  config  | in        | APB psel/penable/pready| paddr, pwdata, prdata (64 bit)
//
// One image byte is decoded per cycle while o_stall is low; the decode state and
// any result are registered at the edge that accepts the beat.
// A skid register behind the output register keeps input flowing while the
// output side stalls; o_stall rises only when both hold a result.
// Reset is synchronous and active low; it restores the configuration reset
// values and starts decoding as if the next byte begins a new image.
module lsb_stego_payload_extractor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lsb_pkg::t_in_item  i_in,
    output logic               o_valid,
    input  logic               i_stall,
    output lsb_pkg::t_out_item o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] PH_SKIP    = 3'd0;
    localparam logic [2:0] PH_MAGIC   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_EXT     = 3'd3;
    localparam logic [2:0] PH_DATALEN = 3'd4;
    localparam logic [2:0] PH_DATA    = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam int LB = lsb_pkg::LengthBits;

    // Configuration registers.
    logic [9:0]  r_header_skip;
    logic [3:0]  r_magic_len;
    logic [63:0] r_magic_value;

    // Decode state.
    logic [2:0]    r_phase,     n_phase;
    logic [9:0]    r_skip,      n_skip;
    logic [4:0]    r_bit_count, n_bit_count;
    logic [LB-1:0] r_shift,     n_shift;
    logic [LB-1:0] r_remain,    n_remain;
    logic [3:0]    r_magic_idx, n_magic_idx;
    logic          r_mismatch,  n_mismatch;

    // Output and skid registers.
    logic               r_out_valid;
    lsb_pkg::t_out_item r_out;
    logic               r_skid_valid;
    lsb_pkg::t_out_item r_skid;

    logic               emit;
    lsb_pkg::t_out_item res;
    logic               in_accept;
    logic               out_take;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [3:0]         eff_len;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:3];
    assign o_stall   = r_skid_valid;
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    // Register read-back.
    always_comb begin
        case (cfg_index)
            lsb_pkg::REG_HEADER_SKIP: prdata = {54'd0, r_header_skip};
            lsb_pkg::REG_MAGIC_LEN:   prdata = {60'd0, r_magic_len};
            lsb_pkg::REG_MAGIC_VALUE: prdata = r_magic_value;
            default:                  prdata = 64'd0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_skip <= lsb_pkg::HEADER_SKIP_RST;
            r_magic_len   <= lsb_pkg::MAGIC_LEN_RST;
            r_magic_value <= lsb_pkg::MAGIC_VALUE_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                lsb_pkg::REG_HEADER_SKIP: r_header_skip <= pwdata[9:0];
                lsb_pkg::REG_MAGIC_LEN:   r_magic_len   <= pwdata[3:0];
                lsb_pkg::REG_MAGIC_VALUE: r_magic_value <= pwdata;
                default: ;
            endcase
        end
    end

    // Magic length is clamped to the largest supported string.
    assign eff_len = (r_magic_len > 4'(lsb_pkg::MaxMagic)) ? 4'(lsb_pkg::MaxMagic)
                                                            : r_magic_len;

    // Next decode state and result for one image byte. The phases fall
    // through in order so that an empty field hands the byte to the next one.
    always_comb begin
        logic          cont;
        logic          bit_in;
        logic [LB-1:0] swn;
        logic [2:0]    byte_sel;
        logic [7:0]    want;
        logic [LB-1:0] len_val;

        n_phase     = r_phase;
        n_skip      = r_skip;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_remain    = r_remain;
        n_magic_idx = r_magic_idx;
        n_mismatch  = r_mismatch;
        emit        = 1'b0;
        res         = '0;
        cont        = 1'b1;
        bit_in      = i_in.image_byte[0];
        byte_sel    = '0;
        want        = '0;
        len_val     = '0;

        if (i_in.first) begin
            n_phase     = PH_SKIP;
            n_skip      = '0;
            n_bit_count = '0;
            n_shift     = '0;
            n_remain    = '0;
            n_magic_idx = '0;
            n_mismatch  = 1'b0;
        end

        swn = {n_shift[LB-2:0], bit_in};

        // Header bytes are dropped.
        if (n_phase == PH_SKIP) begin
            if (n_skip < r_header_skip) begin
                n_skip = n_skip + 10'd1;
                cont   = 1'b0;
            end else begin
                n_phase = PH_MAGIC;
            end
        end

        // Magic characters are compared one at a time.
        if (cont && n_phase == PH_MAGIC) begin
            if (n_magic_idx >= eff_len) begin
                n_bit_count = '0;
                n_shift     = '0;
                swn         = {{(LB-1){1'b0}}, bit_in};
                if (n_mismatch) begin
                    n_phase = PH_DONE;
                    emit    = 1'b1;
                    res     = '{out_byte: 8'd0, kind: lsb_pkg::KIND_MISMATCH, last: 1'b1};
                    cont    = 1'b0;
                end else begin
                    n_phase = PH_EXTLEN;
                end
            end else begin
                cont = 1'b0;
                if (n_bit_count >= 5'd7) begin
                    n_bit_count = '0;
                    byte_sel    = 3'(eff_len - 4'd1 - n_magic_idx);
                    want        = r_magic_value[{byte_sel, 3'b000} +: 8];
                    if (swn[7:0] != want) begin
                        n_mismatch = 1'b1;
                    end
                    n_magic_idx = n_magic_idx + 4'd1;
                    n_shift     = '0;
                    if (n_magic_idx >= eff_len) begin
                        if (n_mismatch) begin
                            n_phase = PH_DONE;
                            emit    = 1'b1;
                            res     = '{out_byte: 8'd0, kind: lsb_pkg::KIND_MISMATCH,
                                        last: 1'b1};
                        end else begin
                            n_phase = PH_EXTLEN;
                        end
                    end
                end else begin
                    n_bit_count = n_bit_count + 5'd1;
                    n_shift     = {{(LB-8){1'b0}}, swn[7:0]};
                end
            end
        end

        // Extension length; a set sign bit counts as zero.
        if (cont && n_phase == PH_EXTLEN) begin
            cont = 1'b0;
            if (n_bit_count >= 5'(LB - 1)) begin
                n_bit_count = '0;
                len_val     = swn[LB-1] ? '0 : swn;
                n_remain    = len_val;
                n_shift     = '0;
                n_phase     = (len_val != '0) ? PH_EXT : PH_DATALEN;
            end else begin
                n_bit_count = n_bit_count + 5'd1;
                n_shift     = swn;
            end
        end

        // Extension characters.
        if (cont && n_phase == PH_EXT) begin
            cont = 1'b0;
            if (n_bit_count >= 5'd7) begin
                n_bit_count = '0;
                n_shift     = '0;
                n_remain    = n_remain - LB'(1);
                if (n_remain == '0) begin
                    n_phase = PH_DATALEN;
                end
                emit = 1'b1;
                res  = '{out_byte: swn[7:0], kind: lsb_pkg::KIND_EXT, last: 1'b0};
            end else begin
                n_bit_count = n_bit_count + 5'd1;
                n_shift     = {{(LB-8){1'b0}}, swn[7:0]};
            end
        end

        // Payload length; zero finishes the image.
        if (cont && n_phase == PH_DATALEN) begin
            cont = 1'b0;
            if (n_bit_count >= 5'(LB - 1)) begin
                n_bit_count = '0;
                len_val     = swn[LB-1] ? '0 : swn;
                n_remain    = len_val;
                n_shift     = '0;
                if (len_val == '0) begin
                    n_phase = PH_DONE;
                    emit    = 1'b1;
                    res     = '{out_byte: 8'd0, kind: lsb_pkg::KIND_EMPTY, last: 1'b1};
                end else begin
                    n_phase = PH_DATA;
                end
            end else begin
                n_bit_count = n_bit_count + 5'd1;
                n_shift     = swn;
            end
        end

        // Payload bytes.
        if (cont && n_phase == PH_DATA) begin
            if (n_bit_count >= 5'd7) begin
                n_bit_count = '0;
                n_shift     = '0;
                n_remain    = n_remain - LB'(1);
                if (n_remain == '0) begin
                    n_phase = PH_DONE;
                end
                emit = 1'b1;
                res  = '{out_byte: swn[7:0], kind: lsb_pkg::KIND_PAYLOAD,
                         last: (n_remain == '0)};
            end else begin
                n_bit_count = n_bit_count + 5'd1;
                n_shift     = {{(LB-8){1'b0}}, swn[7:0]};
            end
        end
    end

    // Decode state advances on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_skip      <= '0;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_remain    <= '0;
            r_magic_idx <= '0;
            r_mismatch  <= 1'b0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_remain    <= n_remain;
            r_magic_idx <= n_magic_idx;
            r_mismatch  <= n_mismatch;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= in_accept && emit;
        end else if (in_accept && emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            if (in_accept && emit) begin
                r_out <= res;
            end
        end else if (in_accept && emit) begin
            r_skid <= res;
        end
    end

endmodule
